### hw/rtl/brs_pkg.sv
// Package for the block reverse stream core: command and release types,
// size constants shared by the front, queue, back and top level.
// No dependencies.
package brs_pkg;

  localparam int MAX_BLOCK_DEF   = 16;
  localparam int MAX_BLOCK_LIMIT = 64;
  localparam int CNT_MAX_W       = $clog2(MAX_BLOCK_LIMIT + 1);
  localparam int SIZE_W          = 5;
  localparam int BYTE_W          = 8;
  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = SIZE_W'(6);

  // one finished block, handed from front to back
  typedef struct packed {
    logic                 bank;
    logic [CNT_MAX_W-1:0] count;
    logic                 reverse;
    logic                 eos;
  } brs_cmd_t;

  // back tells front a bank has been fully read
  typedef struct packed {
    logic valid;
    logic bank;
  } brs_rel_t;

endpackage

### hw/rtl/brs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/brs_front.sv
// Front end: holds the block size register, accepts bytes into the
// ping-pong buffer and issues one command per finished block. Uses brs_pkg.
module brs_front #(
  parameter int MAX_BLOCK = brs_pkg::MAX_BLOCK_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_we,
  input  logic [brs_pkg::SIZE_W-1:0]                   cfg_wdata,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic [brs_pkg::BYTE_W-1:0]                   in_byte,
  input  logic                                         in_eos,
  output logic                                         ram_we,
  output logic [$clog2(MAX_BLOCK):0]                   ram_waddr,
  output logic [brs_pkg::BYTE_W-1:0]                   ram_wdata,
  output logic                                         cmd_push,
  output brs_pkg::brs_cmd_t                            cmd,
  input  brs_pkg::brs_rel_t                            rel
);
  import brs_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCK);
  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int SZ_W  = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

  logic [SIZE_W-1:0] block_size;
  logic [CNT_W-1:0]  fill;
  logic [1:0]        busy;
  logic              wr_bank;

  logic [SZ_W-1:0] size_ext;
  logic [SZ_W-1:0] size_eff;
  logic [SZ_W-1:0] n_ext;
  logic            accept;
  logic            full_blk;
  logic            close_blk;
  logic [1:0]      busy_next;

  always_comb begin
    size_ext = SZ_W'(block_size);
    if (size_ext > SZ_W'(MAX_BLOCK)) begin
      size_eff = SZ_W'(MAX_BLOCK);
    end else if (size_ext == '0) begin
      size_eff = SZ_W'(1);
    end else begin
      size_eff = size_ext;
    end
    n_ext     = SZ_W'(fill) + SZ_W'(1);
    full_blk  = (n_ext >= size_eff);
    close_blk = full_blk || in_eos;
  end

  assign in_ready  = !busy[wr_bank];
  assign accept    = in_valid && in_ready;
  assign ram_we    = accept;
  assign ram_waddr = {wr_bank, fill[IDX_W-1:0]};
  assign ram_wdata = in_byte;
  assign cmd_push  = accept && close_blk;

  always_comb begin
    cmd.bank    = wr_bank;
    cmd.count   = CNT_MAX_W'(n_ext);
    cmd.reverse = full_blk;
    cmd.eos     = in_eos;
  end

  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (accept && close_blk) begin
      busy_next[wr_bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BLOCK_SIZE_RST;
    end else if (cfg_we) begin
      block_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      busy    <= '0;
      wr_bank <= 1'b0;
    end else begin
      busy <= busy_next;
      if (accept) begin
        if (close_blk) begin
          wr_bank <= !wr_bank;
          fill    <= '0;
        end else begin
          fill <= fill + CNT_W'(1);
        end
      end
    end
  end

endmodule

### hw/rtl/brs_cmd_q.sv
// Two-entry command queue between front and back.
// Uses brs_pkg.
module brs_cmd_q (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  brs_pkg::brs_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output brs_pkg::brs_cmd_t head
);
  import brs_pkg::*;

  brs_cmd_t   entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### hw/rtl/brs_back.sv
// Back end: walks one command at a time through the buffer, forward or
// reversed, and drives the output stream through a two-entry skid buffer.
// Uses brs_pkg.
module brs_back #(
  parameter int MAX_BLOCK = brs_pkg::MAX_BLOCK_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  brs_pkg::brs_cmd_t          cmd,
  output logic                       cmd_pop,
  output logic                       ram_re,
  output logic [$clog2(MAX_BLOCK):0] ram_raddr,
  input  logic [brs_pkg::BYTE_W-1:0] ram_rdata,
  output brs_pkg::brs_rel_t          rel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [brs_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_last,
  output logic                       out_done
);
  import brs_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCK);
  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int ENT_W = BYTE_W + 2;

  brs_cmd_t         cur;
  logic             active;
  logic [CNT_W-1:0] idx;
  logic             rd_vld;
  logic             rd_last;
  logic             rd_done;
  logic [ENT_W-1:0] ofifo [2];
  logic             owptr;
  logic             orptr;
  logic [1:0]       occ;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] offset;
  logic             is_last;
  logic [2:0]       credit;
  logic             issue;
  logic             pop_out;
  logic             load;

  always_comb begin
    cnt     = cur.count[CNT_W-1:0];
    is_last = ((idx + CNT_W'(1)) == cnt);
    offset  = cur.reverse ? (cnt - CNT_W'(1) - idx) : idx;
    pop_out = out_valid && out_ready;
    credit  = 3'(occ) + 3'(rd_vld) - 3'(pop_out);
    issue   = active && (credit < 3'd2);
    load    = cmd_valid && (!active || (issue && is_last));
  end

  assign cmd_pop   = load;
  assign ram_re    = issue;
  assign ram_raddr = {cur.bank, offset[IDX_W-1:0]};
  assign rel.valid = issue && is_last;
  assign rel.bank  = cur.bank;

  assign out_valid = (occ != 2'd0);
  assign {out_done, out_last, out_byte} = ofifo[orptr];

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= cmd;
    end
    if (issue) begin
      rd_last <= is_last;
      rd_done <= is_last && cur.eos;
    end
    if (rd_vld) begin
      ofifo[owptr] <= {rd_done, rd_last, ram_rdata};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
      rd_vld <= 1'b0;
      owptr  <= 1'b0;
      orptr  <= 1'b0;
      occ    <= '0;
    end else begin
      if (load) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (issue) begin
        idx <= idx + CNT_W'(1);
        if (is_last) begin
          active <= 1'b0;
        end
      end
      rd_vld <= issue;
      if (rd_vld) begin
        owptr <= !owptr;
      end
      if (pop_out) begin
        orptr <= !orptr;
      end
      occ <= occ + 2'(rd_vld) - 2'(pop_out);
    end
  end

endmodule

### hw/rtl/block_reverse_stream_core.sv
// Block reverse stream core: reverses each full block of block_size bytes;
// a partial block closed by end_of_string is passed on in order.
// Path: a closed block passes the command queue, the back end's command
// register, the RAM read register and the output skid buffer.
// Throughput: up to one byte per cycle; a bank is freed as its last byte is
// read, and input stalls while both banks are held.
// Reset (rst, synchronous): queue and buffers empty, block_size = 6.
module block_reverse_stream_core #(
  parameter int MAX_BLOCK = brs_pkg::MAX_BLOCK_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,     // block_size
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
  input  logic       s_axis_tlast,  // end_of_string
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] out_byte
  output logic       m_axis_tlast,  // run_last
  output logic [0:0] m_axis_tuser   // [0] string_done
);
  import brs_pkg::*;

  localparam int ADDR_W = $clog2(MAX_BLOCK) + 1;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  brs_cmd_t          q_in;
  brs_cmd_t          q_head;
  brs_rel_t          rel;

  brs_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_eos    (s_axis_tlast),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .cmd_push  (q_push),
    .cmd       (q_in),
    .rel       (rel)
  );

  brs_cmd_q u_cmd_q (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  brs_ram #(.WIDTH(BYTE_W), .DEPTH(2 ** ADDR_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  brs_back #(.MAX_BLOCK(MAX_BLOCK)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .rel       (rel),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_done  (m_axis_tuser[0])
  );

`ifndef ASSERT_OFF
  a_q_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command queue overflow");

  a_cmd_count_range: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_in.count != '0) && (q_in.count <= CNT_MAX_W'(MAX_BLOCK)))
    else $error("command count out of range");

  a_no_bank_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr[ADDR_W-1] != ram_raddr[ADDR_W-1]))
    else $error("write into bank being read");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("string_done without run_last");
`endif

endmodule

### verif/tb_block_reverse_stream_core.sv
// Self-checking testbench for block_reverse_stream_core: random bursty byte strings,
// block-size changes between phases, a long output hold-off, per-field result checks.
// Depends on brs_pkg and block_reverse_stream_core.
`timescale 1ns / 100ps

module tb_block_reverse_stream_core;

  import brs_pkg::*;

  localparam int BUF_DEPTH  = MAX_BLOCK_DEF;
  localparam int RAND_ITEMS = 210;
  localparam int SETTLE     = 8;
  localparam int CYC_LIMIT  = 200000;
  localparam int HOLD_LEN   = 150;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              eos;
  } str_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              run_last;
    logic              done;
  } out_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;  // [7:0] data_byte
  logic              s_axis_tlast = 1'b0; // end_of_string
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;        // [7:0] out_byte
  logic              m_axis_tlast;        // run_last
  logic [0:0]        m_axis_tuser;        // [0] string_done

  str_item_t         send_q[$];
  out_item_t         out_q[$];
  int                err_cnt = 0;
  int                cyc = 0;

  // predictor state
  logic [SIZE_W-1:0] mdl_size = BLOCK_SIZE_RST;
  logic [BYTE_W-1:0] blk_buf [BUF_DEPTH];
  int                mdl_fill = 0;

  // driver state
  str_item_t         drv_item;
  int                burst_left = 0;
  int                gap_left = 0;

  // receiver state
  int                hold_left = 0;
  logic              hold_start = 1'b0;
  int                rx_mode = 0;
  int                rx_cnt = 0;

  block_reverse_stream_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_err(string msg);
    $display("ERROR cycle %0d: %s", cyc, msg);
    err_cnt++;
  endtask

  // block reversal with saturating size; partial block flushed in order at end of string
  function automatic void reorder_predict(logic [BYTE_W-1:0] ch, logic eos);
    int sz;
    int n;
    out_item_t o;
    sz = (mdl_size > BUF_DEPTH) ? BUF_DEPTH : ((mdl_size == 0) ? 1 : int'(mdl_size));
    if (mdl_fill < BUF_DEPTH) begin
      blk_buf[mdl_fill] = ch;
      mdl_fill++;
    end
    n = mdl_fill;
    if (n >= sz) begin
      for (int i = 0; i < n; i++) begin
        o.data     = blk_buf[n - 1 - i];
        o.run_last = (i == n - 1);
        o.done     = (i == n - 1) && eos;
        out_q.push_back(o);
      end
      mdl_fill = 0;
    end else if (eos) begin
      for (int i = 0; i < n; i++) begin
        o.data     = blk_buf[i];
        o.run_last = (i == n - 1);
        o.done     = (i == n - 1);
        out_q.push_back(o);
      end
      mdl_fill = 0;
    end
  endfunction

  // driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) reorder_predict(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (send_q.size() > 0) begin
          drv_item = send_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= drv_item.data;
          s_axis_tlast  <= drv_item.eos;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver stall pattern, in one of four randomly chosen modes
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cnt++;
      if (rx_cnt % 50 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: m_axis_tready <= (hold_left == 0);
        1: m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= (hold_left == 0) && rx_cnt[0];
        default: m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (out_q.size() == 0) begin
        report_err($sformatf("unexpected item data=%02h", m_axis_tdata));
      end else begin
        automatic out_item_t e = out_q.pop_front();
        if (m_axis_tdata !== e.data)
          report_err($sformatf("out_byte %02h, want %02h", m_axis_tdata, e.data));
        if (m_axis_tlast !== e.run_last)
          report_err($sformatf("run_last %b, want %b", m_axis_tlast, e.run_last));
        if (m_axis_tuser[0] !== e.done)
          report_err($sformatf("string_done %b, want %b", m_axis_tuser[0], e.done));
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYC_LIMIT) begin
      $display("** block_reverse_stream_core: FAILED **");
      $finish;
    end
  end

  task automatic push_ch(logic [BYTE_W-1:0] ch, logic eos);
    str_item_t it;
    it.data = ch;
    it.eos  = eos;
    send_q.push_back(it);
  endtask

  task automatic push_rand(int len, logic eos_at_end);
    for (int i = 0; i < len; i++)
      push_ch(BYTE_W'($urandom_range(0, 255)), eos_at_end && (i == len - 1));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (send_q.size() != 0 || s_axis_tvalid || out_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_block_size(logic [SIZE_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    mdl_size = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int n_rand;
    int budget;
    int sz;
    int len;
    logic [SIZE_W-1:0] nsize;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset size 6: full block ending the string, then a short partial string
    push_ch(8'h00, 1'b0); push_ch(8'hFF, 1'b0); push_ch(8'h55, 1'b0);
    push_ch(8'hAA, 1'b0); push_ch(8'h01, 1'b0); push_ch(8'h80, 1'b1);
    push_ch(8'h7F, 1'b0); push_ch(8'hFE, 1'b0); push_ch(8'h10, 1'b1);
    // four bytes held, then shrink the size mid-string
    push_ch(8'h11, 1'b0); push_ch(8'h22, 1'b0); push_ch(8'h33, 1'b0); push_ch(8'h44, 1'b0);
    wait_idle();
    set_block_size(5'd2);
    push_ch(8'h55, 1'b0);
    wait_idle();
    set_block_size(5'd0);
    push_ch(8'hC3, 1'b0); push_ch(8'h3C, 1'b1); push_ch(8'hE7, 1'b0);
    wait_idle();
    set_block_size(5'd1);
    push_ch(8'h81, 1'b0); push_ch(8'h18, 1'b1);
    wait_idle();
    // saturated size, string shorter than a block
    set_block_size(5'd31);
    push_rand(5, 1'b1);
    wait_idle();

    // largest block while the output is held off: input must stall
    set_block_size(5'd16);
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    push_rand(48, 1'b0);
    push_rand(12, 1'b1);
    n_rand = 84;
    wait_idle();

    while (n_rand < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0: nsize = 5'd0;
        1: nsize = 5'd1;
        2: nsize = 5'd2;
        3: nsize = 5'd3;
        4: nsize = 5'd5;
        5: nsize = 5'd8;
        6: nsize = 5'd15;
        7: nsize = 5'd16;
        8: nsize = SIZE_W'($urandom_range(17, 31));
        default: nsize = SIZE_W'($urandom_range(0, 31));
      endcase
      set_block_size(nsize);
      sz = (nsize > BUF_DEPTH) ? BUF_DEPTH : ((nsize == 0) ? 1 : int'(nsize));
      budget = $urandom_range(15, 40);
      while (budget > 0) begin
        case ($urandom_range(0, 9))
          7: begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
              push_ch(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          end
          8: begin
            len = 1;
            push_rand(1, 1'b1);
          end
          9: begin
            len = $urandom_range(1, sz);
            push_rand(len, 1'b0);
          end
          default: begin
            len = $urandom_range(1, 2 * sz + 3);
            push_rand(len, 1'b1);
          end
        endcase
        budget -= len;
        n_rand += len;
      end
      wait_idle();
    end

    // flush anything still held
    push_rand(1, 1'b1);
    wait_idle();
    repeat (20) @(posedge clk);

    if (err_cnt == 0) begin
      $display("** block_reverse_stream_core: PASSED **");
    end else begin
      $display("** block_reverse_stream_core: FAILED **");
    end
    $finish;
  end

endmodule

### block_reverse_stream_core.f
hw/rtl/brs_pkg.sv
hw/rtl/brs_ram.sv
hw/rtl/brs_front.sv
hw/rtl/brs_cmd_q.sv
hw/rtl/brs_back.sv
hw/rtl/block_reverse_stream_core.sv
verif/tb_block_reverse_stream_core.sv
